### design/gcn_pkg.sv
// ============================================================================
// gcn_pkg: shared types and constants for the grid neighbor range lookup
// Request and result payloads, opcodes, status codes, register indexes and
// the default sizing of the cell start table.
// ============================================================================
package gcn_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int GCN_MAX_DIM     = 16;
  localparam int GCN_TABLE_DEPTH = 4097;
  localparam int GCN_MAX_POINTS  = 65536;

  // Fixed field widths
  localparam int FRAC_BITS  = 8;
  localparam int POS_W      = 12;
  localparam int IP_W       = POS_W - FRAC_BITS;
  localparam int RANGE_W    = 17;
  localparam int STATUS_W   = 2;
  localparam int DIMREG_W   = 5;
  localparam int BOUND_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HIGH = 3'd4;

  // Register reset values
  localparam logic [DIMREG_W-1:0] DIM_RESET        = 5'd16;
  localparam logic [BOUND_W-1:0]  BOUND_LOW_RESET  = 8'd64;
  localparam logic [BOUND_W-1:0]  BOUND_HIGH_RESET = 8'd192;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER   = 2'd2;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2,
    OP_QUERY  = 2'd3
  } gcn_op_t;

  typedef struct packed {
    gcn_op_t           opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
  } gcn_in_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  range_begin;
    logic [RANGE_W-1:0]  range_end;
    logic [STATUS_W-1:0] status;
    logic                is_last;
  } gcn_out_t;

endpackage

### design/gcn_mac.sv
// ============================================================================
// gcn_mac: shared registered multiply-add unit
// Computes a * b + c, truncated to the width of a, with the result
// registered; the sequencer reuses it for area, volume and cell index.
// ============================================================================
module gcn_mac #(
  parameter int A_W = 13,
  parameter int B_W = 5
) (
  input  logic           clk,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [A_W-1:0] c,
  output logic [A_W-1:0] res
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] sum;
  logic [A_W-1:0] res_r;

  // Multiply and add
  assign sum = P_W'(a) * P_W'(b) + P_W'(c);

  // Register the result
  always_ff @(posedge clk) begin
    res_r <= sum[A_W-1:0];
  end

  assign res = res_r;

endmodule

### design/gcn_tab.sv
// ============================================================================
// gcn_tab: cell start table
// One write port and one read port with registered read data. Addresses at
// or beyond the depth are never written and read as zero.
// ============================================================================
module gcn_tab #(
  parameter int DEPTH = 4097,
  parameter int A_W   = 13,
  parameter int D_W   = 17
) (
  input  logic           clk,
  input  logic           we,
  input  logic [A_W-1:0] waddr,
  input  logic [D_W-1:0] wdata,
  input  logic           re,
  input  logic [A_W-1:0] raddr,
  output logic [D_W-1:0] rdata
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [D_W-1:0] mem [DEPTH];
  logic [D_W-1:0] rd_r;
  logic           oob_r;

  // Write in range only; read with a range flag
  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < DEPTH)) begin
      mem[IDX_W'(waddr)] <= wdata;
    end
    if (re) begin
      rd_r  <= mem[IDX_W'(raddr)];
      oob_r <= !(32'(raddr) < DEPTH);
    end
  end

  // Drop out-of-range reads to zero
  assign rdata = oob_r ? '0 : rd_r;

endmodule

### design/grid_cell_neighbor_range_lookup.sv
// Sequence: each request runs the front states (area, product, two cell index
//   steps) to dispatch; an accepted add point and finish build fill table entries
//   up to their fill bound first; a query gives each range after two table reads.
// Throughput: one request at a time; the next is taken once the last result is
//   registered. Four passes through the shared multiply-add set the front part.
// Reset: registers go to 16/16/16/64/192, fill pointer and point count clear;
//   the start table is not cleared and an entry is valid only once written.
// ============================================================================
// grid_cell_neighbor_range_lookup: uniform grid cell start table and query
// Builds a bordered cell start table from cell-ordered points and returns
// the point index ranges of the neighbor cells around a query position.
// ============================================================================
module grid_cell_neighbor_range_lookup #(
  parameter int MAX_DIM     = gcn_pkg::GCN_MAX_DIM,
  parameter int TABLE_DEPTH = gcn_pkg::GCN_TABLE_DEPTH,
  parameter int MAX_POINTS  = gcn_pkg::GCN_MAX_POINTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gcn_pkg::gcn_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gcn_pkg::gcn_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [gcn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcn_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import gcn_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CELL_W = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 2);
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W  = ((DIM_W > IP_W) ? DIM_W : IP_W) + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_AREA  = 12'b0000_0000_0010,
    S_PROD  = 12'b0000_0000_0100,
    S_CELL0 = 12'b0000_0000_1000,
    S_CELL1 = 12'b0000_0001_0000,
    S_DISP  = 12'b0000_0010_0000,
    S_FILL  = 12'b0000_0100_0000,
    S_EMIT  = 12'b0000_1000_0000,
    S_QINIT = 12'b0001_0000_0000,
    S_QRB   = 12'b0010_0000_0000,
    S_QRE   = 12'b0100_0000_0000,
    S_QOUT  = 12'b1000_0000_0000
  } state_t;

  // Saturate a dimension register to 3..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIMREG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r < DIMREG_W'(3)) begin
      d = DIM_W'(3);
    end else if (32'(r) > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  // Control state
  state_t              state_r, state_nxt;
  logic [DIMREG_W-1:0] dim_x_r, dim_x_nxt, dim_y_r, dim_y_nxt, dim_z_r, dim_z_nxt;
  logic [BOUND_W-1:0]  bound_low_r, bound_low_nxt, bound_high_r, bound_high_nxt;
  logic [CELL_W-1:0]   next_fill_r, next_fill_nxt;
  logic [PCNT_W-1:0]   pcount_r, pcount_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request and work registers
  gcn_op_t             op_r, op_nxt;
  logic [IP_W-1:0]     ip_x_r, ip_x_nxt, ip_y_r, ip_y_nxt, ip_z_r, ip_z_nxt;
  logic                outside_r, outside_nxt;
  logic                xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic                ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic                zlo_r, zlo_nxt, zhi_r, zhi_nxt;
  logic [CELL_W-1:0]   area_r, area_nxt, prod_r, prod_nxt, cell_r, cell_nxt;
  logic [CELL_W-1:0]   fill_last_r, fill_last_nxt;
  logic [CELL_W-1:0]   base_r, base_nxt, zbase_r, zbase_nxt;
  logic                ycnt_r, ycnt_nxt, zcnt_r, zcnt_nxt;
  logic [RANGE_W-1:0]  pend_b_r, pend_b_nxt, pend_e_r, pend_e_nxt;
  logic [STATUS_W-1:0] pend_st_r, pend_st_nxt;
  logic [RANGE_W-1:0]  b_r, b_nxt;
  gcn_out_t            out_data_r, out_data_nxt;

  // Datapath wires
  logic [DIM_W-1:0]    dx, dy, dz;
  logic                in_acc, out_free;
  logic                lo_x, lo_y, lo_z;
  logic                q_more_y, q_more_z, q_last;
  logic [CELL_W-1:0]   mac_a, mac_c, mac_res;
  logic [DIM_W-1:0]    mac_b;
  logic                tab_we, tab_re;
  logic [CELL_W-1:0]   tab_waddr, tab_raddr;
  logic [RANGE_W-1:0]  tab_wdata, tab_rdata;

  assign dx = eff_dim(dim_x_r);
  assign dy = eff_dim(dim_y_r);
  assign dz = eff_dim(dim_z_r);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Lower neighbor wins when both bounds hit
  assign lo_x = in_data.pos_x[FRAC_BITS-1:0] < bound_low_r;
  assign lo_y = in_data.pos_y[FRAC_BITS-1:0] < bound_low_r;
  assign lo_z = in_data.pos_z[FRAC_BITS-1:0] < bound_low_r;

  // Range walk order: y inner, z outer
  assign q_more_y = (ylo_r || yhi_r) && !ycnt_r;
  assign q_more_z = (zlo_r || zhi_r) && !zcnt_r;
  assign q_last   = !q_more_y && !q_more_z;

  // Shared multiply-add unit
  gcn_mac #(
    .A_W (CELL_W),
    .B_W (DIM_W)
  ) u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .res (mac_res)
  );

  // Cell start table
  gcn_tab #(
    .DEPTH (TABLE_DEPTH),
    .A_W   (CELL_W),
    .D_W   (RANGE_W)
  ) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Sequencer and next-state logic
  always_comb begin
    state_nxt      = state_r;
    dim_x_nxt      = dim_x_r;
    dim_y_nxt      = dim_y_r;
    dim_z_nxt      = dim_z_r;
    bound_low_nxt  = bound_low_r;
    bound_high_nxt = bound_high_r;
    next_fill_nxt  = next_fill_r;
    pcount_nxt     = pcount_r;
    out_valid_nxt  = out_valid_r && out_stall;
    op_nxt         = op_r;
    ip_x_nxt       = ip_x_r;
    ip_y_nxt       = ip_y_r;
    ip_z_nxt       = ip_z_r;
    outside_nxt    = outside_r;
    xlo_nxt        = xlo_r;
    xhi_nxt        = xhi_r;
    ylo_nxt        = ylo_r;
    yhi_nxt        = yhi_r;
    zlo_nxt        = zlo_r;
    zhi_nxt        = zhi_r;
    area_nxt       = area_r;
    prod_nxt       = prod_r;
    cell_nxt       = cell_r;
    fill_last_nxt  = fill_last_r;
    base_nxt       = base_r;
    zbase_nxt      = zbase_r;
    ycnt_nxt       = ycnt_r;
    zcnt_nxt       = zcnt_r;
    pend_b_nxt     = pend_b_r;
    pend_e_nxt     = pend_e_r;
    pend_st_nxt    = pend_st_r;
    b_nxt          = b_r;
    out_data_nxt   = out_data_r;
    mac_a          = CELL_W'(dx);
    mac_b          = dy;
    mac_c          = '0;
    tab_we         = 1'b0;
    tab_waddr      = next_fill_r;
    tab_wdata      = RANGE_W'(pcount_r);
    tab_re         = 1'b0;
    tab_raddr      = base_r;

    // Take register writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_DIM_X:      dim_x_nxt      = cfg_wdata[DIMREG_W-1:0];
        CFG_DIM_Y:      dim_y_nxt      = cfg_wdata[DIMREG_W-1:0];
        CFG_DIM_Z:      dim_z_nxt      = cfg_wdata[DIMREG_W-1:0];
        CFG_BOUND_LOW:  bound_low_nxt  = cfg_wdata[BOUND_W-1:0];
        CFG_BOUND_HIGH: bound_high_nxt = cfg_wdata[BOUND_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        // Latch the request, classify each axis
        if (in_acc) begin
          op_nxt      = in_data.opcode;
          ip_x_nxt    = in_data.pos_x[POS_W-1:FRAC_BITS];
          ip_y_nxt    = in_data.pos_y[POS_W-1:FRAC_BITS];
          ip_z_nxt    = in_data.pos_z[POS_W-1:FRAC_BITS];
          outside_nxt =
            (CMP_W'(in_data.pos_x[POS_W-1:FRAC_BITS]) + CMP_W'(2) >= CMP_W'(dx)) ||
            (CMP_W'(in_data.pos_y[POS_W-1:FRAC_BITS]) + CMP_W'(2) >= CMP_W'(dy)) ||
            (CMP_W'(in_data.pos_z[POS_W-1:FRAC_BITS]) + CMP_W'(2) >= CMP_W'(dz));
          xlo_nxt = lo_x;
          xhi_nxt = !lo_x && (in_data.pos_x[FRAC_BITS-1:0] >= bound_high_r);
          ylo_nxt = lo_y;
          yhi_nxt = !lo_y && (in_data.pos_y[FRAC_BITS-1:0] >= bound_high_r);
          zlo_nxt = lo_z;
          zhi_nxt = !lo_z && (in_data.pos_z[FRAC_BITS-1:0] >= bound_high_r);
          state_nxt = S_AREA;
        end
      end
      S_AREA: begin
        // area = dx * dy
        mac_a     = CELL_W'(dx);
        mac_b     = dy;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        // cells in grid = area * dz
        area_nxt  = mac_res;
        mac_a     = mac_res;
        mac_b     = dz;
        state_nxt = S_CELL0;
      end
      S_CELL0: begin
        // (iz + 1) * dy + iy + 1
        prod_nxt  = mac_res;
        mac_a     = CELL_W'(ip_z_r) + CELL_W'(1);
        mac_b     = dy;
        mac_c     = CELL_W'(ip_y_r) + CELL_W'(1);
        state_nxt = S_CELL1;
      end
      S_CELL1: begin
        // ... * dx + ix + 1
        mac_a     = mac_res;
        mac_b     = dx;
        mac_c     = CELL_W'(ip_x_r) + CELL_W'(1);
        state_nxt = S_DISP;
      end
      S_DISP: begin
        cell_nxt = mac_res;
        case (op_r)
          OP_START: begin
            next_fill_nxt = '0;
            pcount_nxt    = '0;
            pend_b_nxt    = '0;
            pend_e_nxt    = '0;
            pend_st_nxt   = ST_OK;
            state_nxt     = S_EMIT;
          end
          OP_FINISH: begin
            fill_last_nxt = prod_r;
            pend_b_nxt    = '0;
            pend_e_nxt    = RANGE_W'(pcount_r);
            pend_st_nxt   = ST_OK;
            state_nxt     = S_FILL;
          end
          OP_ADD: begin
            pend_b_nxt = '0;
            pend_e_nxt = '0;
            if (outside_r) begin
              pend_st_nxt = ST_OUTSIDE;
              state_nxt   = S_EMIT;
            end else if ((32'(pcount_r) >= MAX_POINTS) ||
                         ((CELL_W + 1)'(mac_res) + (CELL_W + 1)'(1) <
                          (CELL_W + 1)'(next_fill_r))) begin
              pend_st_nxt = ST_ORDER;
              state_nxt   = S_EMIT;
            end else begin
              fill_last_nxt = mac_res;
              pend_b_nxt    = RANGE_W'(pcount_r);
              pend_e_nxt    = RANGE_W'(pcount_r + PCNT_W'(1));
              pend_st_nxt   = ST_OK;
              state_nxt     = S_FILL;
            end
          end
          OP_QUERY: begin
            if (outside_r) begin
              pend_b_nxt  = '0;
              pend_e_nxt  = '0;
              pend_st_nxt = ST_OUTSIDE;
              state_nxt   = S_EMIT;
            end else begin
              state_nxt = S_QINIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_FILL: begin
        // Write entries up to the fill bound one per cycle, then count an added point
        if (next_fill_r <= fill_last_r) begin
          tab_we        = 1'b1;
          next_fill_nxt = next_fill_r + CELL_W'(1);
        end else begin
          if (op_r == OP_ADD) begin
            pcount_nxt = pcount_r + PCNT_W'(1);
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.range_begin = pend_b_r;
          out_data_nxt.range_end   = pend_e_r;
          out_data_nxt.status      = pend_st_r;
          out_data_nxt.is_last     = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      S_QINIT: begin
        // Step back to the first neighbor row
        base_nxt  = cell_r - (zlo_r ? area_r : CELL_W'(0)) -
                    (ylo_r ? CELL_W'(dx) : CELL_W'(0));
        zbase_nxt = cell_r - (zlo_r ? area_r : CELL_W'(0)) -
                    (ylo_r ? CELL_W'(dx) : CELL_W'(0));
        ycnt_nxt  = 1'b0;
        zcnt_nxt  = 1'b0;
        state_nxt = S_QRB;
      end
      S_QRB: begin
        // Read range begin, widened down on x
        tab_re    = 1'b1;
        tab_raddr = xlo_r ? (base_r - CELL_W'(1)) : base_r;
        state_nxt = S_QRE;
      end
      S_QRE: begin
        // Hold begin, read range end, widened up on x
        b_nxt     = tab_rdata;
        tab_re    = 1'b1;
        tab_raddr = base_r + (xhi_r ? CELL_W'(2) : CELL_W'(1));
        state_nxt = S_QOUT;
      end
      S_QOUT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.range_begin = b_r;
          out_data_nxt.range_end   = tab_rdata;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.is_last     = q_last;
          // Advance to the next row, then the next slab
          if (q_more_y) begin
            base_nxt  = base_r + CELL_W'(dx);
            ycnt_nxt  = 1'b1;
            state_nxt = S_QRB;
          end else if (q_more_z) begin
            base_nxt  = zbase_r + area_r;
            zbase_nxt = zbase_r + area_r;
            ycnt_nxt  = 1'b0;
            zcnt_nxt  = 1'b1;
            state_nxt = S_QRB;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_x_r      <= DIM_RESET;
      dim_y_r      <= DIM_RESET;
      dim_z_r      <= DIM_RESET;
      bound_low_r  <= BOUND_LOW_RESET;
      bound_high_r <= BOUND_HIGH_RESET;
      next_fill_r  <= '0;
      pcount_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      dim_x_r      <= dim_x_nxt;
      dim_y_r      <= dim_y_nxt;
      dim_z_r      <= dim_z_nxt;
      bound_low_r  <= bound_low_nxt;
      bound_high_r <= bound_high_nxt;
      next_fill_r  <= next_fill_nxt;
      pcount_r     <= pcount_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ip_x_r      <= ip_x_nxt;
    ip_y_r      <= ip_y_nxt;
    ip_z_r      <= ip_z_nxt;
    outside_r   <= outside_nxt;
    xlo_r       <= xlo_nxt;
    xhi_r       <= xhi_nxt;
    ylo_r       <= ylo_nxt;
    yhi_r       <= yhi_nxt;
    zlo_r       <= zlo_nxt;
    zhi_r       <= zhi_nxt;
    area_r      <= area_nxt;
    prod_r      <= prod_nxt;
    cell_r      <= cell_nxt;
    fill_last_r <= fill_last_nxt;
    base_r      <= base_nxt;
    zbase_r     <= zbase_nxt;
    ycnt_r      <= ycnt_nxt;
    zcnt_r      <= zcnt_nxt;
    pend_b_r    <= pend_b_nxt;
    pend_e_r    <= pend_e_nxt;
    pend_st_r   <= pend_st_nxt;
    b_r         <= b_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Fill pointer only moves back on a start build
  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_DISP && op_r == OP_START) |=> next_fill_r >= $past(next_fill_r))
    else $error("fill pointer moved backward outside start build");

  // Point count stays within capacity
  a_pcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pcount_r) <= MAX_POINTS)
    else $error("point count beyond capacity");

  // A result appears only from a result state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT || $past(state_r) == S_QOUT))
    else $error("result raised outside a result state");

  // Table writes stay within the fill bound
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tab_we |-> (state_r == S_FILL && tab_waddr <= fill_last_r))
    else $error("table write beyond fill bound");

endmodule

### test/tb_grid_cell_neighbor_range_lookup.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_grid_cell_neighbor_range_lookup: self-checking bench for the grid lookup
// Walks a short table of directed requests, then runs randomized build and
// query sequences under several register settings and idling patterns.
// Every result is checked field by field against a fixed expected value or
// an in-bench predictor of the cell start table.
// ============================================================================
module tb_grid_cell_neighbor_range_lookup;
  import gcn_pkg::*;

  // Point limit as built into the block
  localparam int POINT_LIMIT = GCN_MAX_POINTS;

  typedef struct {
    bit                     reg_write;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    gcn_in_t                req;
    bit                     fixed;
    gcn_out_t               want;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  gcn_in_t                in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  gcn_out_t               out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predictor state: registers, start table and build cursor
  logic [DIMREG_W-1:0]    reg_dim [3] = '{DIM_RESET, DIM_RESET, DIM_RESET};
  logic [BOUND_W-1:0]     reg_bound_low  = BOUND_LOW_RESET;
  logic [BOUND_W-1:0]     reg_bound_high = BOUND_HIGH_RESET;
  logic [RANGE_W-1:0]     cell_start [GCN_TABLE_DEPTH];
  bit                     entry_written [GCN_TABLE_DEPTH];
  int unsigned            fill_cursor = 0;
  int unsigned            points_held = 0;
  bit                     stale_read;

  gcn_out_t               fresh_ranges [$];
  gcn_out_t               pending_ranges [$];
  gcn_out_t               head;
  stim_row_t              directed_steps [$];

  int unsigned            send_gap_pct   = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            requests_sent  = 0;
  int unsigned            ranges_checked = 0;
  int unsigned            settings_used  = 1;
  int unsigned            mismatches     = 0;

  grid_cell_neighbor_range_lookup #(
    .MAX_POINTS(POINT_LIMIT)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Saturate a dimension register to the supported cell count
  function automatic int unsigned cells_on(int a);
    if (reg_dim[a] < 3) return 3;
    if (reg_dim[a] > GCN_MAX_DIM) return GCN_MAX_DIM;
    return reg_dim[a];
  endfunction

  function automatic gcn_out_t range_word(int unsigned b, int unsigned e,
                                          logic [STATUS_W-1:0] st, bit last);
    gcn_out_t w;
    w.range_begin = b[RANGE_W-1:0];
    w.range_end   = e[RANGE_W-1:0];
    w.status      = st;
    w.is_last     = last;
    return w;
  endfunction

  // Read a start table entry; flag reads of entries never written
  function automatic logic [RANGE_W-1:0] entry_at(longint i);
    if (i < 0 || i >= GCN_TABLE_DEPTH) return '0;
    if (!entry_written[i]) stale_read = 1'b1;
    return cell_start[i];
  endfunction

  // Close every cell from the cursor through the given one
  function automatic void fill_upto(int unsigned last);
    for (int unsigned k = fill_cursor; k <= last && k < GCN_TABLE_DEPTH; k++) begin
      cell_start[k]    = points_held[RANGE_W-1:0];
      entry_written[k] = 1'b1;
    end
  endfunction

  // Work out the results of one request into fresh_ranges and advance the
  // build state; returns 1 when a lookup touches an unwritten entry
  function automatic bit predict_ranges(input gcn_in_t req);
    int unsigned d [3];
    int unsigned ip [3];
    logic [7:0]  fr [3];
    logic [11:0] p [3];
    int          lo [3];
    int          hi [3];
    int unsigned home, total, idx;
    int          n, count;
    longint      addr, area, row;
    bit          outside;
    fresh_ranges.delete();
    stale_read = 1'b0;
    outside = 1'b0;
    p[0] = req.pos_x;
    p[1] = req.pos_y;
    p[2] = req.pos_z;
    for (int a = 0; a < 3; a++) begin
      d[a]  = cells_on(a);
      ip[a] = p[a][11:8];
      fr[a] = p[a][7:0];
      if (ip[a] >= d[a] - 2) outside = 1'b1;
      // lower neighbor wins where the bounds overlap
      if (fr[a] < reg_bound_low) begin
        lo[a] = -1;
        hi[a] = 0;
      end else if (fr[a] >= reg_bound_high) begin
        lo[a] = 0;
        hi[a] = 1;
      end else begin
        lo[a] = 0;
        hi[a] = 0;
      end
    end
    total = d[0] * d[1] * d[2];
    home  = ((ip[2] + 1) * d[1] + ip[1] + 1) * d[0] + ip[0] + 1;

    case (req.opcode)
      OP_START: begin
        fill_cursor = 0;
        points_held = 0;
        fresh_ranges.push_back(range_word(0, 0, ST_OK, 1'b1));
      end
      OP_FINISH: begin
        fill_upto(total);
        if (fill_cursor < total + 1) fill_cursor = total + 1;
        fresh_ranges.push_back(range_word(0, points_held, ST_OK, 1'b1));
      end
      default: begin
        if (outside) begin
          fresh_ranges.push_back(range_word(0, 0, ST_OUTSIDE, 1'b1));
        end else if (req.opcode == OP_ADD) begin
          // drop points behind the closed cells or beyond the limit
          if (points_held >= POINT_LIMIT || home + 1 < fill_cursor) begin
            fresh_ranges.push_back(range_word(0, 0, ST_ORDER, 1'b1));
          end else begin
            fill_upto(home);
            if (fill_cursor < home + 1) fill_cursor = home + 1;
            idx = points_held;
            points_held++;
            fresh_ranges.push_back(range_word(idx, idx + 1, ST_OK, 1'b1));
          end
        end else begin
          // one range per z/y neighbor, widened along x
          row   = d[0];
          area  = row * longint'(d[1]);
          count = (hi[2] - lo[2] + 1) * (hi[1] - lo[1] + 1);
          n = 0;
          for (int dz = lo[2]; dz <= hi[2]; dz++) begin
            for (int dy = lo[1]; dy <= hi[1]; dy++) begin
              addr = longint'(home) + dz * area + dy * row;
              fresh_ranges.push_back(range_word(entry_at(addr + lo[0]),
                                                entry_at(addr + hi[0] + 1),
                                                ST_OK, n == count - 1));
              n++;
            end
          end
        end
      end
    endcase
    return stale_read;
  endfunction

  // Fraction for one axis, biased toward the bounds and the extremes
  function automatic logic [7:0] pick_frac();
    case ($urandom_range(0, 8))
      0: return reg_bound_low;
      1: return reg_bound_low - 8'd1;
      2: return reg_bound_high;
      3: return reg_bound_high - 8'd1;
      4: return 8'h00;
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Request at the n-th interior cell with random fractions
  function automatic gcn_in_t place_request(gcn_op_t op, int unsigned n);
    gcn_in_t     req;
    int unsigned nx, ny, ix, iy, iz;
    nx = cells_on(0) - 2;
    ny = cells_on(1) - 2;
    ix = n % nx;
    iy = (n / nx) % ny;
    iz = n / (nx * ny);
    req.opcode = op;
    req.pos_x  = {ix[3:0], pick_frac()};
    req.pos_y  = {iy[3:0], pick_frac()};
    req.pos_z  = {iz[3:0], pick_frac()};
    return req;
  endfunction

  function automatic gcn_in_t raw_request(gcn_op_t op);
    gcn_in_t req;
    req.opcode = op;
    req.pos_x  = 12'($urandom);
    req.pos_y  = 12'($urandom);
    req.pos_z  = 12'($urandom);
    return req;
  endfunction

  function automatic void stim_item(gcn_op_t op, logic [11:0] x, logic [11:0] y,
                                    logic [11:0] z, bit fixed = 1'b0,
                                    int unsigned b = 0, int unsigned e = 0,
                                    logic [STATUS_W-1:0] st = ST_OK);
    stim_row_t row;
    row.reg_write  = 1'b0;
    row.reg_index  = '0;
    row.reg_value  = '0;
    row.req.opcode = op;
    row.req.pos_x  = x;
    row.req.pos_y  = y;
    row.req.pos_z  = z;
    row.fixed      = fixed;
    row.want       = range_word(b, e, st, 1'b1);
    directed_steps.push_back(row);
  endfunction

  function automatic void stim_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.reg_write = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    row.req       = '0;
    row.fixed     = 1'b0;
    row.want      = '0;
    directed_steps.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Write one register; the block must be idle
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DIM_X:      reg_dim[0] = val[DIMREG_W-1:0];
      CFG_DIM_Y:      reg_dim[1] = val[DIMREG_W-1:0];
      CFG_DIM_Z:      reg_dim[2] = val[DIMREG_W-1:0];
      CFG_BOUND_LOW:  reg_bound_low = val;
      CFG_BOUND_HIGH: reg_bound_high = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Present one request, hold it through stalls, then queue its results
  task automatic send_request(input gcn_in_t req, input bit fixed = 1'b0,
                              input gcn_out_t want = '0);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(predict_ranges(req));
    if (fixed) begin
      pending_ranges.push_back(want);
    end else begin
      foreach (fresh_ranges[i]) pending_ranges.push_back(fresh_ranges[i]);
    end
    requests_sent++;
  endtask

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      ranges_checked++;
      if (pending_ranges.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        head = pending_ranges.pop_front();
        if (out_data.range_begin !== head.range_begin)
          flag_mismatch($sformatf("range_begin %0d, expected %0d",
                                  out_data.range_begin, head.range_begin));
        if (out_data.range_end !== head.range_end)
          flag_mismatch($sformatf("range_end %0d, expected %0d",
                                  out_data.range_end, head.range_end));
        if (out_data.status !== head.status)
          flag_mismatch($sformatf("status %0d, expected %0d",
                                  out_data.status, head.status));
        if (out_data.is_last !== head.is_last)
          flag_mismatch($sformatf("is_last %0b, expected %0b",
                                  out_data.is_last, head.is_last));
      end
    end
  end

  initial begin
    #400_000_000;
    $display("timeout with %0d results outstanding", pending_ranges.size());
    $display("grid_cell_neighbor_range_lookup regression: fail");
    $finish;
  end

  initial begin
    gcn_in_t     req;
    int unsigned dx, dy, dz, bl, bh;
    int unsigned interior, k, m, n, step, seq_no, phase_end;

    // Build after reset: two points in the first interior cell, one in the last
    stim_item(OP_START, 12'h000, 12'h000, 12'h000, 1'b1, 0, 0);
    stim_item(OP_ADD, 12'h000, 12'h000, 12'h000, 1'b1, 0, 1);
    stim_item(OP_ADD, 12'h0FF, 12'h000, 12'h000, 1'b1, 1, 2);
    stim_item(OP_ADD, 12'hDFF, 12'hDFF, 12'hDFF, 1'b1, 2, 3);
    // Point behind the closed cells, then each axis outside the box (x and z just outside)
    stim_item(OP_ADD, 12'h000, 12'h000, 12'h000, 1'b1, 0, 0, ST_ORDER);
    stim_item(OP_ADD, 12'hE00, 12'h000, 12'h000, 1'b1, 0, 0, ST_OUTSIDE);
    stim_item(OP_QUERY, 12'h000, 12'hFFF, 12'h000, 1'b1, 0, 0, ST_OUTSIDE);
    stim_item(OP_QUERY, 12'h000, 12'h000, 12'hE00, 1'b1, 0, 0, ST_OUTSIDE);
    stim_item(OP_FINISH, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 0, 3);
    stim_item(OP_ADD, 12'hDFF, 12'hDFF, 12'hDFF, 1'b1, 0, 0, ST_ORDER);
    // Queries: centered, all lower, all upper, fractions on the bounds
    stim_item(OP_QUERY, 12'h080, 12'h080, 12'h080);
    stim_item(OP_QUERY, 12'h000, 12'h000, 12'h000);
    stim_item(OP_QUERY, 12'hDFF, 12'hDFF, 12'hDFF);
    stim_item(OP_QUERY, 12'h03F, 12'h040, 12'h0BF);
    stim_item(OP_QUERY, 12'h0C0, 12'h03F, 12'h0C0);
    // Overlapping bounds: lower neighbor wins
    stim_reg(CFG_BOUND_LOW, 8'd200);
    stim_reg(CFG_BOUND_HIGH, 8'd100);
    stim_item(OP_QUERY, 12'h096, 12'h096, 12'h096);
    stim_item(OP_QUERY, 12'h5C8, 12'h3C8, 12'h7C8);
    stim_reg(CFG_BOUND_LOW, 8'd0);
    stim_reg(CFG_BOUND_HIGH, 8'd0);
    stim_item(OP_QUERY, 12'h700, 12'h7FF, 12'h780);
    stim_reg(CFG_BOUND_LOW, 8'd255);
    stim_reg(CFG_BOUND_HIGH, 8'd255);
    stim_item(OP_QUERY, 12'hAFE, 12'hAFF, 12'hA00);
    // Empty build
    stim_item(OP_START, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 0, 0);
    stim_item(OP_FINISH, 12'h000, 12'h000, 12'h000, 1'b1, 0, 0);
    stim_item(OP_QUERY, 12'hD00, 12'h000, 12'h700);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].reg_write) begin
        in_valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge clk);
        set_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
      end else begin
        cfg_we <= 1'b0;
        send_request(directed_steps[i].req, directed_steps[i].fixed,
                     directed_steps[i].want);
      end
    end

    // Random phases: new settings and idling pattern each time
    seq_no = 0;
    for (int phase = 0; phase < 8; phase++) begin
      in_valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clk);
      case (phase)
        0: begin
          dx = 3; dy = 3; dz = 3; bl = 0; bh = 255;
        end
        1: begin
          dx = 0; dy = 1; dz = 2; bl = 255; bh = 0;
        end
        2: begin
          dx = 31; dy = 16; dz = 17; bl = 128; bh = 128;
        end
        3: begin
          dx = 5; dy = 9; dz = 4; bl = 64; bh = 192;
        end
        default: begin
          dx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(3, 8);
          dy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(3, 8);
          dz = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(3, 8);
          bl = $urandom_range(0, 255);
          bh = $urandom_range(0, 255);
        end
      endcase
      set_register(CFG_DIM_X, 8'(dx));
      set_register(CFG_DIM_Y, 8'(dy));
      set_register(CFG_DIM_Z, 8'(dz));
      set_register(CFG_BOUND_LOW, 8'(bl));
      set_register(CFG_BOUND_HIGH, 8'(bh));
      cfg_we <= 1'b0;
      settings_used++;
      case (phase % 4)
        0: begin
          send_gap_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 51; recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0; recv_stall_pct = 51;
        end
        default: begin
          send_gap_pct = 11; recv_stall_pct = 11;
        end
      endcase

      interior  = (cells_on(0) - 2) * (cells_on(1) - 2) * (cells_on(2) - 2);
      phase_end = requests_sent + 37;
      while (requests_sent < phase_end) begin
        seq_no++;
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed build with ascending cells, then queries on it
          k    = (seq_no % 5 == 1) ? $urandom_range(30, 40) : $urandom_range(0, 12);
          step = (k == 0) ? 1 : (2 * interior) / k + 1;
          n    = 0;
          send_request(raw_request(OP_START));
          for (int j = 0; j < k; j++) begin
            n += $urandom_range(0, step);
            if (n >= interior) n = interior - 1;
            send_request(place_request(OP_ADD, n));
          end
          send_request(raw_request(OP_FINISH));
          m = $urandom_range(2, 8);
          for (int j = 0; j < m; j++)
            send_request(place_request(OP_QUERY, $urandom_range(0, interior - 1)));
        end else begin
          // Noise: any opcode anywhere; push unsafe lookups out of the box
          m = $urandom_range(1, 4);
          for (int j = 0; j < m; j++) begin
            req = raw_request(gcn_op_t'($urandom_range(0, 3)));
            if (req.opcode == OP_QUERY && predict_ranges(req)) req.pos_x[11:8] = 4'hF;
            send_request(req);
          end
        end
      end
    end

    // Drain, then let any stray result show up
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests under %0d register settings, %0d results checked",
             requests_sent, settings_used, ranges_checked);
    $display("idling: none, sender gaps, receiver stalls, both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("grid_cell_neighbor_range_lookup regression: pass");
    end else begin
      $display("grid_cell_neighbor_range_lookup regression: fail");
    end
    $finish;
  end

endmodule

### grid_cell_neighbor_range_lookup.f
design/gcn_pkg.sv
design/gcn_mac.sv
design/gcn_tab.sv
design/grid_cell_neighbor_range_lookup.sv
test/tb_grid_cell_neighbor_range_lookup.sv
